>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the spline corridor block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define GSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, masked while reset is asserted.
`define GSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define GSC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/gsc_pkg.sv
// Package with sizes, codes, result type and cross-product helper of the corridor builder.
`timescale 1ns / 1ps

package gsc_pkg;

    // Spline point table size and derived count width
    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int KEY_W  = 32;
    localparam int LOC_W  = 32;
    localparam int IDX_W  = 10;
    localparam int ME_W   = 16;
    localparam int CODE_W = 2;

    localparam logic [ME_W-1:0] MAX_ERROR_RESET = ME_W'(8);

    // Stream widths
    localparam int S_TDATA_W = KEY_W;
    localparam int M_PAY_W   = IDX_W + KEY_W + LOC_W;
    localparam int M_TDATA_W = ((M_PAY_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_PAY_W;
    localparam int M_TUSER_W = 1 + CODE_W;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // Result codes
    typedef enum logic [CODE_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_ORDER = 2'd1,
        ERR_FULL  = 2'd2
    } err_code_t;

    // One result item
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [KEY_W-1:0] key;
        logic [LOC_W-1:0] loc;
        logic             temporary;
        err_code_t        code;
        logic             last;
    } res_t;

    // Signed differences and cross products
    typedef logic signed [33:0] diff_t;
    typedef logic signed [67:0] prod_t;
    typedef logic signed [68:0] cross_t;

    // Exact a*b - c*d
    function automatic cross_t cross_diff(diff_t a, diff_t b, diff_t c, diff_t d);
        prod_t p1;
        prod_t p2;
        p1 = a * b;
        p2 = c * d;
        return cross_t'(p1) - cross_t'(p2);
    endfunction

endpackage

>>> rtl/greedy_spline_corridor_builder_top.sv
// Greedy spline corridor builder: one key in, up to two spline point writes out.
// A key's results pass through the input register and the result queue before they are offered on m_.
// Throughput: one key per cycle while m_tready is high and keys give at most one result each;
//   a key that commits a point gives two, and the one-result-per-cycle output port sets the rate.
// The corridor test (eight 34x34-bit products) runs in the single stage after the input register.
// Reset (aresetn low, synchronous) clears all corridor state and the result queue; max_error -> 8.
`timescale 1ns / 1ps

module greedy_spline_corridor_builder_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Key requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gsc_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] key
    input  logic                          s_tlast,   // end_of_set
    // Point write requests
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gsc_pkg::M_TDATA_W-1:0] m_tdata,   // [9:0] point_index, [41:10] point_key,
                                                     // [73:42] point_loc, [79:74] zero
    output logic [gsc_pkg::M_TUSER_W-1:0] m_tuser,   // [0] temporary, [2:1] error_code
    output logic                          m_tlast,   // last
    // max_error register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gsc_pkg::ME_W-1:0]      cfg_data
);

    localparam int KW = gsc_pkg::KEY_W;
    localparam int LW = gsc_pkg::LOC_W;
    localparam int CW = gsc_pkg::CNT_W;

    // Configuration
    logic [gsc_pkg::ME_W-1:0] max_error_reg;

    // Input register
    logic          in_valid_reg;
    logic [KW-1:0] in_key_reg;
    logic          in_eos_reg;

    // Corridor state
    logic [LW-1:0] position_reg, position_next;
    logic [CW-1:0] point_count_reg, point_count_next;
    logic          trail_temp_reg, trail_temp_next;
    logic [KW-1:0] anchor_key_reg, anchor_key_next;
    logic [LW-1:0] anchor_loc_reg, anchor_loc_next;
    logic [KW-1:0] prev_key_reg, prev_key_next;
    logic [LW-1:0] prev_loc_reg, prev_loc_next;
    logic [KW-1:0] upper_key_reg, upper_key_next;
    logic [LW:0]   upper_loc_reg, upper_loc_next;
    logic [KW-1:0] lower_key_reg, lower_key_next;
    logic [LW-1:0] lower_loc_reg, lower_loc_next;

    // Result queue
    gsc_pkg::res_t                fifo_reg [gsc_pkg::FIFO_DEPTH];
    logic [gsc_pkg::FPTR_W-1:0]   wr_ptr_reg;
    logic [gsc_pkg::FPTR_W-1:0]   rd_ptr_reg;
    logic [gsc_pkg::FCNT_W-1:0]   fifo_cnt_reg;

    // Stage control
    logic          proc_fire;
    logic          pop;
    logic [1:0]    n_res;
    gsc_pkg::res_t res_a;
    gsc_pkg::res_t res_b;

    // Corridor arithmetic
    logic [CW-1:0]         c_base;
    logic [CW-1:0]         c_plus;
    logic [CW:0]           need;
    logic                  table_full;
    logic [LW-1:0]         low_new;
    logic [LW:0]           up_new;
    gsc_pkg::diff_t        xd, yd, uxd, uyd, lxd, lyd, uy_new, ly_new;
    gsc_pkg::cross_t       cr_up, cr_lo, cr_tu, cr_tl;
    logic                  left_up, right_lo, tight_up, tight_lo, outside;

    assign cfg_ready = 1'b1;

    // Stage advances when the queue has room for two results
    assign proc_fire = in_valid_reg &&
                       (fifo_cnt_reg <= gsc_pkg::FCNT_W'(gsc_pkg::FIFO_DEPTH - 2));
    assign s_tready  = !in_valid_reg || proc_fire;

    // Corridor bounds for the current position
    assign low_new = (position_reg < LW'(max_error_reg)) ? '0
                                                          : position_reg - LW'(max_error_reg);
    assign up_new  = {1'b0, position_reg} + (LW+1)'(max_error_reg);

    // Offsets from the anchor
    assign xd     = {2'b00, in_key_reg}    - {2'b00, anchor_key_reg};
    assign yd     = {2'b00, position_reg}  - {2'b00, anchor_loc_reg};
    assign uxd    = {2'b00, upper_key_reg} - {2'b00, anchor_key_reg};
    assign uyd    = {1'b0, upper_loc_reg}  - {2'b00, anchor_loc_reg};
    assign lxd    = {2'b00, lower_key_reg} - {2'b00, anchor_key_reg};
    assign lyd    = {2'b00, lower_loc_reg} - {2'b00, anchor_loc_reg};
    assign uy_new = {1'b0, up_new}         - {2'b00, anchor_loc_reg};
    assign ly_new = {2'b00, low_new}       - {2'b00, anchor_loc_reg};

    // Cross-product tests against both bounds
    assign cr_up    = gsc_pkg::cross_diff(yd, uxd, uyd, xd);
    assign cr_lo    = gsc_pkg::cross_diff(yd, lxd, lyd, xd);
    assign cr_tu    = gsc_pkg::cross_diff(uyd, xd, uy_new, uxd);
    assign cr_tl    = gsc_pkg::cross_diff(lyd, xd, ly_new, lxd);
    assign left_up  = !cr_up[$bits(cr_up)-1] && (|cr_up);
    assign right_lo = cr_lo[$bits(cr_lo)-1];
    assign tight_up = !cr_tu[$bits(cr_tu)-1] && (|cr_tu);
    assign tight_lo = cr_tl[$bits(cr_tl)-1];
    assign outside  = left_up || right_lo;

    // Table occupancy
    assign c_base     = point_count_reg - CW'(trail_temp_reg);
    assign c_plus     = c_base + CW'(1);
    assign need       = {1'b0, c_base} + (outside ? (CW+1)'(2) : (CW+1)'(1));
    assign table_full = need > (CW+1)'(gsc_pkg::MAX_POINTS);

    // Next state and results of the held key
    always_comb begin
        position_next    = position_reg;
        point_count_next = point_count_reg;
        trail_temp_next  = trail_temp_reg;
        anchor_key_next  = anchor_key_reg;
        anchor_loc_next  = anchor_loc_reg;
        prev_key_next    = prev_key_reg;
        prev_loc_next    = prev_loc_reg;
        upper_key_next   = upper_key_reg;
        upper_loc_next   = upper_loc_reg;
        lower_key_next   = lower_key_reg;
        lower_loc_next   = lower_loc_reg;
        n_res            = 2'd0;
        res_a            = '0;
        res_b            = '0;

        if (proc_fire) begin
            priority if (position_reg == '0) begin
                // First key: fixed point at slot 0
                n_res            = 2'd1;
                res_a.key        = in_key_reg;
                res_a.last       = 1'b1;
                point_count_next = CW'(1);
                trail_temp_next  = 1'b0;
                anchor_key_next  = in_key_reg;
                anchor_loc_next  = '0;
                prev_key_next    = in_key_reg;
                prev_loc_next    = '0;
                position_next    = LW'(1);
            end else if (in_key_reg < prev_key_reg) begin
                n_res      = 2'd1;
                res_a.code = gsc_pkg::ERR_ORDER;
                res_a.last = 1'b1;
            end else if (position_reg == LW'(1)) begin
                // Second key: open the corridor
                lower_key_next = in_key_reg;
                lower_loc_next = low_new;
                upper_key_next = in_key_reg;
                upper_loc_next = up_new;
                prev_key_next  = in_key_reg;
                prev_loc_next  = position_reg;
                position_next  = LW'(2);
            end else if (in_key_reg == prev_key_reg) begin
                position_next = position_reg + LW'(1);
            end else if (table_full) begin
                n_res      = 2'd1;
                res_a.code = gsc_pkg::ERR_FULL;
                res_a.last = 1'b1;
            end else begin
                if (outside) begin
                    // Commit the previous point and restart the corridor
                    n_res            = 2'd2;
                    res_a.index      = gsc_pkg::IDX_W'(c_base);
                    res_a.key        = prev_key_reg;
                    res_a.loc        = prev_loc_reg;
                    res_b.index      = gsc_pkg::IDX_W'(c_plus);
                    res_b.key        = in_key_reg;
                    res_b.loc        = position_reg;
                    res_b.temporary  = 1'b1;
                    res_b.last       = 1'b1;
                    point_count_next = c_plus + CW'(1);
                    anchor_key_next  = prev_key_reg;
                    anchor_loc_next  = prev_loc_reg;
                    lower_key_next   = in_key_reg;
                    lower_loc_next   = low_new;
                    upper_key_next   = in_key_reg;
                    upper_loc_next   = up_new;
                end else begin
                    // Tighten the bounds
                    n_res            = 2'd1;
                    res_a.index      = gsc_pkg::IDX_W'(c_base);
                    res_a.key        = in_key_reg;
                    res_a.loc        = position_reg;
                    res_a.temporary  = 1'b1;
                    res_a.last       = 1'b1;
                    point_count_next = c_plus;
                    if (tight_up) begin
                        upper_key_next = in_key_reg;
                        upper_loc_next = up_new;
                    end
                    if (tight_lo) begin
                        lower_key_next = in_key_reg;
                        lower_loc_next = low_new;
                    end
                end
                prev_key_next   = in_key_reg;
                prev_loc_next   = position_reg;
                position_next   = position_reg + LW'(1);
                trail_temp_next = 1'b1;
            end

            // Drop all state after the final key of a set
            if (in_eos_reg) begin
                position_next    = '0;
                point_count_next = '0;
                trail_temp_next  = 1'b0;
                anchor_key_next  = '0;
                anchor_loc_next  = '0;
                prev_key_next    = '0;
                prev_loc_next    = '0;
                upper_key_next   = '0;
                upper_loc_next   = '0;
                lower_key_next   = '0;
                lower_loc_next   = '0;
            end
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_error_reg <= gsc_pkg::MAX_ERROR_RESET;
        end else if (cfg_valid) begin
            max_error_reg <= cfg_data;
        end
    end

    // Input register: load on accept, drop when processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_key_reg <= s_tdata[KW-1:0];
            in_eos_reg <= s_tlast;
        end
    end

    // Corridor state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg    <= '0;
            point_count_reg <= '0;
            trail_temp_reg  <= 1'b0;
            anchor_key_reg  <= '0;
            anchor_loc_reg  <= '0;
            prev_key_reg    <= '0;
            prev_loc_reg    <= '0;
            upper_key_reg   <= '0;
            upper_loc_reg   <= '0;
            lower_key_reg   <= '0;
            lower_loc_reg   <= '0;
        end else begin
            position_reg    <= position_next;
            point_count_reg <= point_count_next;
            trail_temp_reg  <= trail_temp_next;
            anchor_key_reg  <= anchor_key_next;
            anchor_loc_reg  <= anchor_loc_next;
            prev_key_reg    <= prev_key_next;
            prev_loc_reg    <= prev_loc_next;
            upper_key_reg   <= upper_key_next;
            upper_loc_reg   <= upper_loc_next;
            lower_key_reg   <= lower_key_next;
            lower_loc_reg   <= lower_loc_next;
        end
    end

    // Result queue: push up to two, pop one
    assign pop = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res_a;
        end
        if (n_res == 2'd2) begin
            fifo_reg[wr_ptr_reg + gsc_pkg::FPTR_W'(1)] <= res_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            wr_ptr_reg   <= wr_ptr_reg + gsc_pkg::FPTR_W'(n_res);
            rd_ptr_reg   <= rd_ptr_reg + gsc_pkg::FPTR_W'(pop);
            fifo_cnt_reg <= fifo_cnt_reg + gsc_pkg::FCNT_W'(n_res) - gsc_pkg::FCNT_W'(pop);
        end
    end

    // Present the queue head
    assign m_tvalid = fifo_cnt_reg != '0;
    assign m_tdata  = {{gsc_pkg::M_PAD_W{1'b0}}, fifo_reg[rd_ptr_reg].loc,
                       fifo_reg[rd_ptr_reg].key, fifo_reg[rd_ptr_reg].index};
    assign m_tuser  = {fifo_reg[rd_ptr_reg].code, fifo_reg[rd_ptr_reg].temporary};
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;

endmodule

>>> rtl/gsc_checker.sv
// Port-level checker of the corridor builder, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gsc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gsc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [gsc_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);

    logic is_err;

    assign is_err = m_tvalid && (m_tuser[2:1] != gsc_pkg::ERR_NONE);

    // Reset empties the result queue
    `GSC_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)
    // A stalled result stays offered
    `GSC_ASSERT_NXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // An error is the only result of its key and carries no point
    `GSC_ASSERT_IMP(a_err_single, aclk, aresetn, is_err, m_tlast && (m_tdata == '0) && !m_tuser[0])
    // The trailing point always closes its key's results
    `GSC_ASSERT_IMP(a_temp_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)

endmodule

bind greedy_spline_corridor_builder_top gsc_checker u_gsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
